// File: src/plc_pkg.sv
// Shared types, constants and helper functions for the piecewise level compressor.
package plc_pkg;

  // Sizes of the datapath.
  localparam int SEGMENTS   = 6;
  localparam int MAX_PASSES = 5;
  localparam int SAMPLE_W   = 24;
  localparam int THR_W      = 23;
  localparam int PC_W       = 3;
  localparam int PASS_W     = $clog2(MAX_PASSES + 1);
  localparam int CMP_W      = (PASS_W > PC_W) ? PASS_W : PC_W;
  localparam int SEG_W      = $clog2(SEGMENTS);
  localparam int SLOPE_W    = 17;
  localparam int RND_SHIFT  = 16;
  localparam int PROD_W     = SAMPLE_W + SLOPE_W;
  localparam int RND_W      = PROD_W - RND_SHIFT;
  localparam int OFF_W      = 26;
  localparam int SUM_W      = 27;

  // Configuration port.
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = THR_W;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_NOISE_THRESHOLD = 1'b0,
    REG_PASS_COUNT      = 1'b1
  } cfg_reg_t;

  // Curve segments, in the order they are tested.
  typedef enum logic [SEG_W-1:0] {
    SEG_FLOOR = 3'd0,
    SEG_NOISE = 3'd1,
    SEG_LOW   = 3'd2,
    SEG_MID   = 3'd3,
    SEG_HIGH  = 3'd4,
    SEG_TOP   = 3'd5
  } seg_t;

  // Breakpoints (Q22) and slopes (Q16).
  localparam longint LIM0_V = 419;
  localparam longint LIM2_V = 419430;
  localparam longint LIM3_V = 1258291;
  localparam longint LIM4_V = 2097152;
  localparam longint LIM5_V = 4194304;
  localparam longint K0_V   = 52429;
  localparam longint K1_V   = 65536;
  localparam longint K2_V   = 78643;
  localparam longint K3_V   = 78643;
  localparam longint K4_V   = 65536;
  localparam longint K5_V   = 52429;
  localparam longint HALF_V = 32768;

  localparam logic [SAMPLE_W-1:0] LIM0 = SAMPLE_W'(LIM0_V);
  localparam logic [SAMPLE_W-1:0] LIM2 = SAMPLE_W'(LIM2_V);
  localparam logic [SAMPLE_W-1:0] LIM3 = SAMPLE_W'(LIM3_V);
  localparam logic [SAMPLE_W-1:0] LIM4 = SAMPLE_W'(LIM4_V);
  localparam logic [SAMPLE_W-1:0] LIM5 = SAMPLE_W'(LIM5_V);

  localparam logic [SLOPE_W-1:0] SLOPE_NOISE_CURVE = SLOPE_W'(K2_V);
  localparam logic [PROD_W-1:0]  RND_HALF          = PROD_W'(HALF_V);

  localparam logic signed [SAMPLE_W-1:0] NEAR_ONE = SAMPLE_W'(4152361);
  localparam logic signed [SUM_W-1:0]    SUM_SAT_HI = SUM_W'((64'sd1 <<< (SAMPLE_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0]    SUM_SAT_LO = SUM_W'(-(64'sd1 <<< (SAMPLE_W - 1)));

  // Reset values of the configuration registers.
  localparam longint THR_RST_V = 4194;
  localparam logic [PASS_W-1:0] PASS_RST = PASS_W'(2);

  // Rounded Q16 product of two constants, used at elaboration only.
  function automatic longint cround(input longint a, input longint b);
    return (a * b + HALF_V) >>> RND_SHIFT;
  endfunction

  // Segment offsets. Each one from the low segment up is a constant plus the term that follows the
  // threshold, d = thr - round(thr * slope of the low segment).
  localparam longint E0_V       = cround(LIM0_V, K0_V);
  localparam longint OFF_NOISE_V = E0_V - cround(LIM0_V, K1_V);
  localparam longint OFF_LOW_V  = OFF_NOISE_V;
  localparam longint OFF_MID_V  = OFF_LOW_V + cround(LIM2_V, K2_V) - cround(LIM2_V, K3_V);
  localparam longint OFF_HIGH_V = OFF_MID_V + cround(LIM3_V, K3_V) - cround(LIM3_V, K4_V);
  localparam longint OFF_TOP_V  = OFF_HIGH_V + cround(LIM4_V, K4_V) - cround(LIM4_V, K5_V);
  localparam longint D_RST_V    = THR_RST_V - cround(THR_RST_V, K2_V);

  localparam logic signed [OFF_W-1:0] OFF_NOISE = OFF_W'(OFF_NOISE_V);
  localparam logic signed [OFF_W-1:0] OFF_LOW   = OFF_W'(OFF_LOW_V);
  localparam logic signed [OFF_W-1:0] OFF_MID   = OFF_W'(OFF_MID_V);
  localparam logic signed [OFF_W-1:0] OFF_HIGH  = OFF_W'(OFF_HIGH_V);
  localparam logic signed [OFF_W-1:0] OFF_TOP   = OFF_W'(OFF_TOP_V);

  // Payload of the two channels.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       block_end;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       block_end_out;
  } out_t;

  // Sample as it travels from pass to pass.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic                       blk;
  } stage_t;

  // Curve settings that follow from the threshold register.
  typedef struct packed {
    logic [THR_W-1:0]        thr;
    logic signed [OFF_W-1:0] off_low;
    logic signed [OFF_W-1:0] off_mid;
    logic signed [OFF_W-1:0] off_high;
    logic signed [OFF_W-1:0] off_top;
  } curve_t;

  localparam curve_t CURVE_RST = '{
    thr:      THR_W'(THR_RST_V),
    off_low:  OFF_W'(D_RST_V + OFF_LOW_V),
    off_mid:  OFF_W'(D_RST_V + OFF_MID_V),
    off_high: OFF_W'(D_RST_V + OFF_HIGH_V),
    off_top:  OFF_W'(D_RST_V + OFF_TOP_V)
  };

  // Slope of each segment.
  function automatic logic [SLOPE_W-1:0] seg_slope(input seg_t seg);
    logic [SLOPE_W-1:0] k;
    case (seg)
      SEG_FLOOR: k = SLOPE_W'(K0_V);
      SEG_NOISE: k = SLOPE_W'(K1_V);
      SEG_LOW:   k = SLOPE_W'(K2_V);
      SEG_MID:   k = SLOPE_W'(K3_V);
      SEG_HIGH:  k = SLOPE_W'(K4_V);
      SEG_TOP:   k = SLOPE_W'(K5_V);
      default:   k = '0;
    endcase
    return k;
  endfunction

endpackage

// File: src/piecewise_level_compressor.sv
// Top level of the piecewise level compressor: configuration registers and pass pipeline.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_ready    in_data  (sample_in, block_end)
//   output    out        out_valid / out_ready  out_data (sample_out, block_end_out)
//   config    in         cfg_wen                cfg_addr, cfg_wdata
//
// One sample is accepted per cycle unless the pipeline stalls; each crosses every pass unit.
// Every pass unit has two register stages, a segment search and a rounded multiply.
// Passes beyond the configured count carry the sample through unchanged.
// When the output holds a transaction that is not taken, the whole pipeline stalls.
// Reset clears the valid bits and restores the configuration; nothing else is cleared.
module piecewise_level_compressor import plc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_wen,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers; the curve offsets are derived as the threshold is written.
  curve_t             curve;
  curve_t             curve_next;
  logic [PASS_W-1:0]  passes;
  logic [PASS_W-1:0]  passes_next;
  logic [THR_W-1:0]   thr_w;
  logic [PROD_W-1:0]  thr_prod;
  logic [RND_W-1:0]   thr_rnd;
  logic signed [OFF_W-1:0] d;
  logic [CMP_W-1:0]   pc;

  always_comb begin
    thr_w    = cfg_wdata[THR_W-1:0];
    thr_prod = PROD_W'(thr_w) * PROD_W'(SLOPE_NOISE_CURVE);
    thr_rnd  = RND_W'((thr_prod + RND_HALF) >> RND_SHIFT);
    d        = OFF_W'(thr_w) - OFF_W'(thr_rnd);
    curve_next.thr      = thr_w;
    curve_next.off_low  = d + OFF_LOW;
    curve_next.off_mid  = d + OFF_MID;
    curve_next.off_high = d + OFF_HIGH;
    curve_next.off_top  = d + OFF_TOP;

    // Pass count zero means one pass; counts above the maximum are clamped.
    pc = CMP_W'(cfg_wdata[PC_W-1:0]);
    if (pc == '0) begin
      passes_next = PASS_W'(1);
    end else if (pc > CMP_W'(MAX_PASSES)) begin
      passes_next = PASS_W'(MAX_PASSES);
    end else begin
      passes_next = pc[PASS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      curve  <= CURVE_RST;
      passes <= PASS_RST;
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_addr))
        REG_NOISE_THRESHOLD: curve  <= curve_next;
        REG_PASS_COUNT:      passes <= passes_next;
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register is free or being taken.
  logic adv;
  logic   stage_vld  [0:MAX_PASSES];
  stage_t stage_data [0:MAX_PASSES];

  assign adv      = !stage_vld[MAX_PASSES] || out_ready;
  assign in_ready = adv;

  assign stage_vld[0]      = in_valid;
  assign stage_data[0].x   = in_data.sample_in;
  assign stage_data[0].blk = in_data.block_end;

  // One pass unit per possible pass.
  for (genvar p = 0; p < MAX_PASSES; p++) begin : g_pass
    logic pass_on;
    assign pass_on = (PASS_W'(p) < passes);

    plc_pass u_pass (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_vld   (stage_vld[p]),
      .in_data  (stage_data[p]),
      .pass_on  (pass_on),
      .curve    (curve),
      .out_vld  (stage_vld[p+1]),
      .out_data (stage_data[p+1])
    );
  end

  // The last pass register is the output register.
  assign out_valid              = stage_vld[MAX_PASSES];
  assign out_data.sample_out    = stage_data[MAX_PASSES].x;
  assign out_data.block_end_out = stage_data[MAX_PASSES].blk;

endmodule

// File: src/plc_pass.sv
// One pass of the gain curve, split into a segment-select stage and a multiply stage.
module plc_pass import plc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  logic   in_vld,
  input  stage_t in_data,
  input  logic   pass_on,
  input  curve_t curve,
  output logic   out_vld,
  output stage_t out_data
);

  // Stage A: magnitude, sign and segment search.
  logic                neg;
  logic [SAMPLE_W-1:0] xu;
  logic [SAMPLE_W-1:0] mag;
  logic                hit;
  seg_t                seg;

  always_comb begin
    xu  = in_data.x;
    neg = in_data.x[SAMPLE_W-1];
    mag = neg ? (~xu + 1'b1) : xu;
    hit = 1'b1;
    if (mag <= LIM0) begin
      seg = SEG_FLOOR;
    end else if (mag <= {1'b0, curve.thr}) begin
      seg = SEG_NOISE;
    end else if (mag <= LIM2) begin
      seg = SEG_LOW;
    end else if (mag <= LIM3) begin
      seg = SEG_MID;
    end else if (mag <= LIM4) begin
      seg = SEG_HIGH;
    end else if (mag <= LIM5) begin
      seg = SEG_TOP;
    end else begin
      seg = SEG_FLOOR;
      hit = 1'b0;
    end
  end

  logic                       a_vld;
  logic                       a_on;
  logic                       a_hit;
  logic                       a_neg;
  seg_t                       a_seg;
  logic [SAMPLE_W-1:0]        a_mag;
  logic signed [SAMPLE_W-1:0] a_x;
  logic                       a_blk;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_on  <= pass_on;
      a_hit <= hit;
      a_neg <= neg;
      a_seg <= seg;
      a_mag <= mag;
      a_x   <= in_data.x;
      a_blk <= in_data.blk;
    end
  end

  // Stage B: rounded product, offset, sign and saturation.
  logic [SLOPE_W-1:0]        slope;
  logic [PROD_W-1:0]         prod;
  logic [RND_W-1:0]          rnd;
  logic signed [OFF_W-1:0]   off;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   res;
  logic signed [SAMPLE_W-1:0] sat;
  logic signed [SAMPLE_W-1:0] y;

  always_comb begin
    slope = seg_slope(a_seg);
    prod  = PROD_W'(a_mag) * PROD_W'(slope);
    rnd   = RND_W'((prod + RND_HALF) >> RND_SHIFT);
    case (a_seg)
      SEG_FLOOR: off = '0;
      SEG_NOISE: off = OFF_NOISE;
      SEG_LOW:   off = curve.off_low;
      SEG_MID:   off = curve.off_mid;
      SEG_HIGH:  off = curve.off_high;
      SEG_TOP:   off = curve.off_top;
      default:   off = '0;
    endcase
    sum = $signed({{(SUM_W - RND_W){1'b0}}, rnd}) + {{(SUM_W - OFF_W){off[OFF_W-1]}}, off};
    res = a_neg ? -sum : sum;
    if (res > SUM_SAT_HI) begin
      sat = SUM_SAT_HI[SAMPLE_W-1:0];
    end else if (res < SUM_SAT_LO) begin
      sat = SUM_SAT_LO[SAMPLE_W-1:0];
    end else begin
      sat = res[SAMPLE_W-1:0];
    end
    if (!a_on) begin
      y = a_x;
    end else if (!a_hit) begin
      y = NEAR_ONE;
    end else begin
      y = sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.x   <= y;
      out_data.blk <= a_blk;
    end
  end

  // A disabled pass hands the sample on untouched.
  a_off_keeps: assert property (@(posedge clk) disable iff (rst)
    (adv && a_vld && !a_on) |=> (out_data.x == $past(a_x)))
    else $error("disabled pass changed the sample");

  // The curve never turns a non-negative sample negative.
  a_sign_kept: assert property (@(posedge clk) disable iff (rst)
    (adv && a_vld && a_on && !a_neg) |=> !out_data.x[SAMPLE_W-1])
    else $error("non-negative sample came out negative");

  // Only a magnitude above every breakpoint misses all segments.
  a_miss_big: assert property (@(posedge clk) disable iff (rst)
    (a_vld && !a_hit) |-> ((a_mag > LIM5) && (a_mag > {1'b0, curve.thr})))
    else $error("segment search missed a magnitude in range");

  // A stalled stage keeps its valid bit and its sample.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(out_vld) && $stable(out_data)))
    else $error("stalled stage changed");

endmodule

// File: test/plc_level_checker.sv
// Checker for the piecewise level compressor: predicts each levelled sample and compares.
module plc_level_checker import plc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_t                   in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_t                  out_data,
  input  logic                  cfg_wen,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    outstanding,
  output int                    mismatches,
  output int                    samples_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // Register values after reset and the fixed output levels; threshold and levels are Q22.
  localparam logic [THR_W-1:0] THR_AT_RESET    = THR_W'(4194);
  localparam logic [PC_W-1:0]  PASSES_AT_RESET = PC_W'(2);
  localparam longint           Q22_NEAR_ONE    = 4152361;
  localparam longint           Q22_MAX         = 8388607;
  localparam longint           Q22_MIN         = -8388608;

  // Local copy of the configuration registers.
  logic [THR_W-1:0] thr_reg;
  logic [PC_W-1:0]  passes_reg;

  // Levelled samples still to come out, oldest first.
  out_t levelled_q[$];

  // Unsigned Q16 product, rounded half up.
  function automatic longint round_q16(input longint mag, input longint k);
    return (mag * k + 32768) >>> 16;
  endfunction

  // Applies the gain curve to one sample as many times as the pass count asks.
  function automatic logic signed [SAMPLE_W-1:0] level_curve(
    input logic signed [SAMPLE_W-1:0] sample,
    input logic [THR_W-1:0]           thr,
    input logic [PC_W-1:0]            pc
  );
    longint bound  [SEGMENTS];
    longint gain   [SEGMENTS];
    longint offset [SEGMENTS];
    longint x;
    longint mag;
    longint r;
    longint seg_end;
    int     passes;
    bit     neg;
    bit     hit;
    // Breakpoints: 0.0001, threshold, 0.1, 0.3, 0.5, 1.0; slopes 0.8, 1.0, 1.2, 1.2, 1.0, 0.8.
    bound = '{419, 0, 419430, 1258291, 2097152, 4194304};
    gain  = '{52429, 65536, 78643, 78643, 65536, 52429};
    bound[1] = longint'(thr);
    // Offsets chain each segment onto the end of the previous one.
    offset[0] = 0;
    seg_end = round_q16(bound[0], gain[0]);
    for (int f = 1; f < SEGMENTS; f++) begin
      offset[f] = seg_end - round_q16(bound[f-1], gain[f]);
      seg_end = round_q16(bound[f], gain[f]) + offset[f];
    end
    // A pass count of zero means one pass; large counts stop at the maximum.
    if (pc == 0) passes = 1;
    else if (int'(pc) > MAX_PASSES) passes = MAX_PASSES;
    else passes = int'(pc);
    x = longint'(sample);
    for (int p = 0; p < passes; p++) begin
      neg = (x < 0);
      mag = neg ? -x : x;
      hit = 1'b0;
      r = Q22_NEAR_ONE;
      // The first segment whose breakpoint covers the magnitude wins.
      for (int f = 0; f < SEGMENTS; f++) begin
        if (!hit && mag <= bound[f]) begin
          hit = 1'b1;
          r = round_q16(mag, gain[f]) + offset[f];
          if (neg) r = -r;
          if (r > Q22_MAX) r = Q22_MAX;
          if (r < Q22_MIN) r = Q22_MIN;
        end
      end
      x = r;
    end
    return SAMPLE_W'(x);
  endfunction

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Follow configuration writes, check results and queue predictions.
  always @(posedge clk) begin : monitor
    out_t expected;
    if (rst) begin
      thr_reg = THR_AT_RESET;
      passes_reg = PASSES_AT_RESET;
      levelled_q.delete();
      outstanding <= 0;
    end else begin
      if (cfg_wen) begin
        case (cfg_reg_t'(cfg_addr))
          REG_NOISE_THRESHOLD: thr_reg = cfg_wdata[THR_W-1:0];
          REG_PASS_COUNT:      passes_reg = cfg_wdata[PC_W-1:0];
          default: ;
        endcase
      end
      // A result transaction is matched against the oldest prediction.
      if (out_valid && out_ready) begin
        if (levelled_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with no sample pending",
                                    $signed(out_data.sample_out)));
        end else begin
          expected = levelled_q.pop_front();
          samples_checked++;
          if (out_data.sample_out !== expected.sample_out)
            report_mismatch($sformatf("sample_out %0d, expected %0d",
                                      $signed(out_data.sample_out),
                                      $signed(expected.sample_out)));
          if (out_data.block_end_out !== expected.block_end_out)
            report_mismatch($sformatf("block_end_out %b, expected %b",
                                      out_data.block_end_out, expected.block_end_out));
        end
      end
      // Each input transaction yields exactly one levelled sample.
      if (in_valid && in_ready) begin
        expected.sample_out = level_curve(in_data.sample_in, thr_reg, passes_reg);
        expected.block_end_out = in_data.block_end;
        levelled_q.push_back(expected);
      end
      outstanding <= levelled_q.size();
    end
  end

endmodule

// File: test/tb_piecewise_level_compressor.sv
// Testbench top for the piecewise level compressor: stimulus, idling and verdict.
module tb_piecewise_level_compressor;
  timeunit 1ns;
  timeprecision 1ps;
  import plc_pkg::*;

  localparam int PHASES           = 10;
  localparam int RANDOM_PER_PHASE = 170;
  localparam int SETTLE_CYCLES    = 2 * MAX_PASSES + 4;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_wen = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = REG_NOISE_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int pending;
  int mismatches;
  int checked;
  int sent;
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  int stall_left = 0;
  logic [THR_W-1:0] cur_thr = THR_W'(4194);

  // Corner samples at the reset curve: zero, breakpoint edges, full scale, bit patterns.
  logic signed [SAMPLE_W-1:0] corner_samples [23] = '{
    24'sd0, 24'sd1, -24'sd1, 24'sd419, 24'sd420, -24'sd420, 24'sd4194, 24'sd4195,
    -24'sd4195, 24'sd419430, 24'sd419431, -24'sd1258291, 24'sd1258292, 24'sd2097152,
    -24'sd2097153, 24'sd4194304, 24'sd4194305, -24'sd4194304, 24'sd8388607,
    -24'sd8388608, -24'sd8388607, 24'sh555555, -24'sh555556
  };

  // Curve settings and idling rates, one per phase; the last phase runs without idling.
  logic [THR_W-1:0] phase_thr [PHASES] = '{
    23'd4194, 23'd0, 23'd419, 23'd41943, 23'd419430, 23'd4194304, 23'd8388607,
    23'd1258291, 23'd0, 23'd4194
  };
  int phase_passes [PHASES] = '{2, 1, 5, 3, 0, 7, 6, 4, 5, 2};
  int phase_tx_pct [PHASES] = '{20, 0, 30, 15, 40, 10, 25, 0, 20, 0};
  int phase_rx_pct [PHASES] = '{25, 30, 0, 15, 40, 20, 10, 0, 35, 0};

  piecewise_level_compressor dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  plc_level_checker level_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_wen         (cfg_wen),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .outstanding     (pending),
    .mismatches      (mismatches),
    .samples_checked (checked)
  );

  always #10 clk = ~clk;

  // Receiver: random stall bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 10);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Offers one sample, after an optional gap, and waits for its transaction.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic b);
    if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{sample_in: s, block_end: b};
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Stops sending and waits until every levelled sample has been checked.
  task automatic drain_levels;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Writes both registers while the pipeline is empty.
  task automatic set_curve(input logic [THR_W-1:0] thr, input int pc);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_addr <= REG_NOISE_THRESHOLD;
    cfg_wdata <= CFG_DATA_W'(thr);
    @(posedge clk);
    cfg_addr <= REG_PASS_COUNT;
    cfg_wdata <= CFG_DATA_W'(pc);
    @(posedge clk);
    cfg_wen <= 1'b0;
    cur_thr = thr;
  endtask

  // Random sample aimed at one region of the curve, with a random sign.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    longint mag;
    longint base;
    case ($urandom_range(0, 9))
      0: mag = $urandom_range(0, 600);
      1: mag = longint'(cur_thr) + longint'($urandom_range(0, 64)) - 32;
      2: mag = $urandom_range(0, 419430);
      3: mag = $urandom_range(419430, 1258291);
      4: mag = $urandom_range(1258291, 2097152);
      5: mag = $urandom_range(2097152, 4194304);
      6: begin
        // Just around one of the breakpoints.
        case ($urandom_range(0, 5))
          0: base = 419;
          1: base = longint'(cur_thr);
          2: base = 419430;
          3: base = 1258291;
          4: base = 2097152;
          default: base = 4194304;
        endcase
        mag = base + longint'($urandom_range(0, 4)) - 2;
      end
      7: mag = $urandom_range(4194304, 8388608);
      default: return SAMPLE_W'($urandom());
    endcase
    if (mag < 0) mag = 0;
    if ($urandom_range(0, 1) == 1) mag = -mag;
    return SAMPLE_W'(mag);
  endfunction

  // Main stimulus: corners at reset settings, then random phases over several curves.
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    tx_gap_pct = 20;
    rx_stall_pct = 20;
    for (int i = 0; i < $size(corner_samples); i++)
      send_sample(corner_samples[i], i[0]);
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_levels();
      if (ph == 8)
        set_curve(THR_W'($urandom_range(420, 419429)), phase_passes[ph]);
      else
        set_curve(phase_thr[ph], phase_passes[ph]);
      tx_gap_pct = phase_tx_pct[ph];
      rx_stall_pct = phase_rx_pct[ph];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // Once, let the pipeline empty completely in the middle of a phase.
        if (ph == 3 && n == RANDOM_PER_PHASE / 2) drain_levels();
        send_sample(pick_sample(), 1'($urandom_range(0, 1)));
      end
    end
    drain_levels();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d samples over %0d curve settings, pass counts 0 to 7,",
             sent, PHASES + 1);
    $display("thresholds 0 to full scale; %0d levelled samples compared.", checked);
    if (mismatches == 0)
      $display("PASS piecewise_level_compressor");
    else
      $display("FAIL piecewise_level_compressor");
    $finish;
  end

  // Safety net against a hung handshake.
  initial begin
    #10_000_000;
    $display("FAIL piecewise_level_compressor");
    $finish;
  end

endmodule
